@@ rtl/bnc_pkg.sv @@
// ----------------------------------------------------------------------------
// bnc_pkg: shared types and constants of the nearest coordinate scaler
// Holds the coordinate width, the derived datapath widths, the item
// structures of both ports and the sideband that runs beside the divider.
// ----------------------------------------------------------------------------
package bnc_pkg;

  // Width at which the coordinate fields are interpreted.
  localparam int unsigned COORD_BITS = 16;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned OUT_W      = 15;
  localparam int unsigned HI_W       = 16;
  localparam int unsigned EXT_W      = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  // Differences of two coordinates.
  localparam int unsigned DIF_W      = COORD_BITS + 1;
  // Twice a difference plus one.
  localparam int unsigned MUL_A_W    = COORD_BITS + 2;
  // Signed product of the two above.
  localparam int unsigned PROD_W     = MUL_A_W + DIF_W;
  // Magnitudes of numerator and denominator.
  localparam int unsigned NUM_W      = 2 * COORD_BITS + 1;
  localparam int unsigned DEN_W      = COORD_BITS + 1;
  // Signed quotient after the offset has been added.
  localparam int unsigned SUM_W      = NUM_W + 2;

  localparam int unsigned DIV_STAGES = NUM_W;
  localparam int unsigned LATENCY    = DIV_STAGES + 5;

  localparam logic signed [HI_W-1:0] HI_MAX = HI_W'(32767);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dst_coord;
    logic signed [FIELD_W-1:0] dst_begin;
    logic signed [FIELD_W-1:0] dst_end;
    logic signed [FIELD_W-1:0] src_begin;
    logic signed [FIELD_W-1:0] src_end;
    logic        [FIELD_W-1:0] src_size;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] src_coord;
    logic             empty_axis;
  } out_item_t;

  // Per-item values that bypass the divider.
  typedef struct packed {
    logic                   empty;
    logic                   neg;
    coord_t                 sb;
    logic signed [HI_W-1:0] hi;
  } side_t;

  // A field is read from its low COORD_BITS bits; a wider coordinate sees the
  // field zero extended.
  function automatic coord_t coord_value(logic [FIELD_W-1:0] raw);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(raw);
    return coord_t'(ext[COORD_BITS-1:0]);
  endfunction

endpackage

@@ rtl/bnc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// bnc_div_pipe: pipelined restoring divider
// Unsigned division of the numerator magnitude by the denominator magnitude,
// one quotient bit per register stage, with a sideband carried alongside.
// ----------------------------------------------------------------------------
module bnc_div_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [bnc_pkg::NUM_W-1:0] num_i,
  input  logic [bnc_pkg::DEN_W-1:0] den_i,
  input  bnc_pkg::side_t        side_i,
  output logic                  valid_o,
  output logic [bnc_pkg::NUM_W-1:0] quo_o,
  output logic                  rem_nz_o,
  output bnc_pkg::side_t        side_o
);
  import bnc_pkg::*;

  logic             valid_q [DIV_STAGES];
  logic [DEN_W-1:0] rem_q   [DIV_STAGES];
  logic [NUM_W-1:0] w_q     [DIV_STAGES];
  logic [DEN_W-1:0] den_q   [DIV_STAGES];
  side_t            side_q  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] w_in;
    logic [DEN_W-1:0] den_in;
    side_t            side_in;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_d;
    logic [NUM_W-1:0] w_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign w_in    = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign w_in    = w_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // The quotient bits shift in at the bottom as the numerator leaves the top.
    assign trial = {rem_in, w_in[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_in});
    assign rem_d = fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
    assign w_d   = {w_in[NUM_W-2:0], fits};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      w_q[k]    <= w_d;
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o  = valid_q[DIV_STAGES-1];
  assign quo_o    = w_q[DIV_STAGES-1];
  assign rem_nz_o = |rem_q[DIV_STAGES-1];
  assign side_o   = side_q[DIV_STAGES-1];

endmodule

@@ rtl/blit_nearest_coordinate_scaler.sv @@
// ----------------------------------------------------------------------------
// blit_nearest_coordinate_scaler: nearest-filter source coordinate, one axis
// Maps a destination texel coordinate to the source texel sampled at its
// centre, with mirrored regions, clamping to the source image and an empty
// region flag.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy, so
// start may be held high for a whole run of texels. Each result appears on
// result_o for a single cycle, marked by result_valid_o, once its item has
// passed through every register of the pipeline, and results leave in the
// order in which the items arrived. The receiver cannot hold results off,
// so it must take each one in the cycle in which it is shown. The datapath
// is an exact floor division that produces one quotient bit per pipeline
// stage, with three stages ahead of it and two behind it.
// ----------------------------------------------------------------------------
module blit_nearest_coordinate_scaler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  bnc_pkg::in_item_t  item_i,
  output logic               busy,
  output logic               result_valid_o,
  output bnc_pkg::out_item_t result_o
);
  import bnc_pkg::*;

  // The pipeline never stalls, so a new item is always welcome.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: the coordinate differences, the centre offset and the upper clamp.
  // The half-texel offset becomes the odd factor 2(d-db)+1 over 2(de-db), so
  // that no rounding happens before the final floor.
  // --------------------------------------------------------------------------
  logic                     s1_valid_q;
  logic signed [MUL_A_W-1:0] s1_a_q, s1_a_d;
  logic signed [DIF_W-1:0]  s1_ds_q, s1_ds_d;
  logic signed [DIF_W-1:0]  s1_dn_q, s1_dn_d;
  side_t                    s1_side_q, s1_side_d;

  always_comb begin
    coord_t                  d, db, de, sb, se;
    logic signed [DIF_W-1:0] dd;
    d  = coord_value(item_i.dst_coord);
    db = coord_value(item_i.dst_begin);
    de = coord_value(item_i.dst_end);
    sb = coord_value(item_i.src_begin);
    se = coord_value(item_i.src_end);

    dd      = DIF_W'(d) - DIF_W'(db);
    s1_a_d  = $signed({dd, 1'b1});
    s1_ds_d = DIF_W'(se) - DIF_W'(sb);
    s1_dn_d = DIF_W'(de) - DIF_W'(db);

    s1_side_d.empty = (de == db);
    s1_side_d.neg   = 1'b0;
    s1_side_d.sb    = sb;
    // A zero size gives an upper bound of minus one, which the lower clamp
    // then lifts to zero. Sizes beyond the output range stop at its top.
    if (item_i.src_size > FIELD_W'(32768)) begin
      s1_side_d.hi = HI_MAX;
    end else begin
      s1_side_d.hi = $signed(HI_W'(item_i.src_size - FIELD_W'(1)));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the signed product that forms the numerator, and the denominator.
  // --------------------------------------------------------------------------
  logic                      s2_valid_q;
  logic signed [PROD_W-1:0]  s2_prod_q, s2_prod_d;
  logic signed [DEN_W:0]     s2_den_q, s2_den_d;
  side_t                     s2_side_q;

  assign s2_prod_d = PROD_W'(s1_a_q) * PROD_W'(s1_ds_q);
  assign s2_den_d  = $signed({s1_dn_q, 1'b0});

  // --------------------------------------------------------------------------
  // Stage 3: magnitudes for the unsigned divider and the sign of the quotient.
  // --------------------------------------------------------------------------
  logic                     s3_valid_q;
  logic [NUM_W-1:0]         s3_num_q, s3_num_d;
  logic [DEN_W-1:0]         s3_den_q, s3_den_d;
  side_t                    s3_side_q, s3_side_d;

  always_comb begin
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [DEN_W:0]    den_abs;
    prod_abs  = s2_prod_q[PROD_W-1] ? -s2_prod_q : s2_prod_q;
    den_abs   = s2_den_q[DEN_W] ? -s2_den_q : s2_den_q;
    s3_num_d  = prod_abs[NUM_W-1:0];
    s3_den_d  = den_abs[DEN_W-1:0];
    s3_side_d     = s2_side_q;
    s3_side_d.neg = s2_prod_q[PROD_W-1] ^ s2_den_q[DEN_W];
  end

  // --------------------------------------------------------------------------
  // Divider stages.
  // --------------------------------------------------------------------------
  logic             div_valid;
  logic [NUM_W-1:0] div_quo;
  logic             div_rem_nz;
  side_t            div_side;

  bnc_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid_q),
    .num_i    (s3_num_q),
    .den_i    (s3_den_q),
    .side_i   (s3_side_q),
    .valid_o  (div_valid),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz),
    .side_o   (div_side)
  );

  // --------------------------------------------------------------------------
  // Stage 4: floor for a negative quotient (round the magnitude up when there
  // is a remainder, then negate) and add the source begin.
  // --------------------------------------------------------------------------
  logic                    s4_valid_q;
  logic signed [SUM_W-1:0] s4_sum_q, s4_sum_d;
  side_t                   s4_side_q;

  always_comb begin
    logic [SUM_W-1:0]        mag;
    logic signed [SUM_W-1:0] qs;
    mag      = SUM_W'(div_quo) + SUM_W'(div_side.neg & div_rem_nz);
    qs       = div_side.neg ? -$signed(mag) : $signed(mag);
    s4_sum_d = qs + SUM_W'(div_side.sb);
  end

  // --------------------------------------------------------------------------
  // Stage 5: clamp to the source image and register the result.
  // --------------------------------------------------------------------------
  logic      s5_valid_q;
  out_item_t s5_res_q, s5_res_d;

  always_comb begin
    logic signed [HI_W-1:0]  hi;
    logic signed [SUM_W-1:0] hi_ext;
    logic signed [SUM_W-1:0] c;
    hi     = s4_side_q.hi;
    hi_ext = SUM_W'(hi);
    c      = (s4_sum_q > hi_ext) ? hi_ext : s4_sum_q;
    if (c < 0) begin
      c = '0;
    end
    if (s4_side_q.empty) begin
      s5_res_d.src_coord  = '0;
      s5_res_d.empty_axis = 1'b1;
    end else begin
      s5_res_d.src_coord  = c[OUT_W-1:0];
      s5_res_d.empty_axis = 1'b0;
    end
  end

  // Valid bits carry reset; the payload registers do not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= div_valid;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q    <= s1_a_d;
    s1_ds_q   <= s1_ds_d;
    s1_dn_q   <= s1_dn_d;
    s1_side_q <= s1_side_d;
    s2_prod_q <= s2_prod_d;
    s2_den_q  <= s2_den_d;
    s2_side_q <= s1_side_q;
    s3_num_q  <= s3_num_d;
    s3_den_q  <= s3_den_d;
    s3_side_q <= s3_side_d;
    s4_sum_q  <= s4_sum_d;
    s4_side_q <= div_side;
    s5_res_q  <= s5_res_d;
  end

  assign result_valid_o = s5_valid_q;
  assign result_o       = s5_res_q;

endmodule

@@ rtl/bnc_checker.sv @@
// ----------------------------------------------------------------------------
// bnc_checker: port-level checks of the nearest coordinate scaler
// Watches the ports for the fixed latency, the empty region flag and the
// clamp to the source image size.
// ----------------------------------------------------------------------------
module bnc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input bnc_pkg::in_item_t  item_i,
  input logic               busy,
  input logic               result_valid_o,
  input bnc_pkg::out_item_t result_o
);
  import bnc_pkg::*;

  logic taken;
  logic taken_empty;

  assign taken       = start && !busy;
  assign taken_empty = taken &&
                       (coord_value(item_i.dst_begin) == coord_value(item_i.dst_end));

  // Every item taken gives one result a fixed time later.
  a_latency_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken |-> ##LATENCY result_valid_o)
    else $error("no result at the expected latency");

  // No result appears without an item behind it.
  a_latency_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !taken |-> ##LATENCY !result_valid_o)
    else $error("result without an item");

  // An empty destination region is flagged on its own result, with coordinate 0.
  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_empty |-> ##LATENCY (result_valid_o && result_o.empty_axis &&
                               (result_o.src_coord == '0)))
    else $error("empty region not reported");

  // The coordinate stays inside the source image.
  a_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.empty_axis &&
     ($past(item_i.src_size, LATENCY) != '0)) |->
    (FIELD_W'(result_o.src_coord) < $past(item_i.src_size, LATENCY)))
    else $error("source coordinate outside the image");

endmodule

bind blit_nearest_coordinate_scaler bnc_checker u_bnc_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the nearest coordinate scaler
// A queue of axis items, directed corner cases first and then random blit
// set-ups, feeds a clocked driver that sends them in bursts with random gaps.
// A clocked monitor checks every result strobe, in order, against the source
// coordinates that an independent integer predictor has worked out.
// ----------------------------------------------------------------------------
module tb_top;

  import bnc_pkg::*;

  localparam int unsigned NUM_RANDOM   = 530;
  localparam int unsigned MAX_REPORTS  = 10;
  // Cycles in which neither an item nor a result moves before the run is
  // given up. The longest correct lull is a sender gap plus the pipeline.
  localparam int unsigned STALL_LIMIT  = 500;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      start      = 1'b0;
  in_item_t  axis_item  = '0;
  logic      busy;
  logic      result_valid_o;
  out_item_t result_o;

  // Axis items waiting to be sent, and the results owed by the block for
  // items it has already taken, oldest first.
  in_item_t  axis_req_q[$];
  out_item_t src_coord_due_q[$];

  int unsigned items_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned directed_cnt  = 0;
  int unsigned empty_cnt     = 0;
  int unsigned mirrored_cnt  = 0;

  blit_nearest_coordinate_scaler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (axis_item),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reset is held low from the start and released on a falling edge, well away
  // from the edges at which the driver and the monitor act.
  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A coordinate field is read as a two's complement number of COORD_BITS
  // bits taken from the low end of the field.
  function automatic longint coord_of(logic [FIELD_W-1:0] raw);
    longint unsigned mask;
    longint          v;
    mask = (64'd1 << COORD_BITS) - 64'd1;
    v    = longint'(64'(raw) & mask);
    if (v[COORD_BITS-1]) v = v - longint'(mask) - 1;
    return v;
  endfunction

  // Source texel sampled at the centre of destination texel d. The half
  // texel offset is carried as a factor of two on both sides of the
  // division, so the only rounding is the final floor towards minus infinity.
  function automatic out_item_t nearest_src_coord(in_item_t it);
    longint    d, db, de, sb, se;
    longint    num, den, q, hi;
    out_item_t r;
    d  = coord_of(it.dst_coord);
    db = coord_of(it.dst_begin);
    de = coord_of(it.dst_end);
    sb = coord_of(it.src_begin);
    se = coord_of(it.src_end);
    r  = '0;
    if (de == db) begin
      r.empty_axis = 1'b1;
      return r;
    end
    num = (2 * (d - db) + 1) * (se - sb);
    den = 2 * (de - db);
    q   = num / den;
    // Division truncates towards zero; step down when the exact quotient
    // is negative and not whole.
    if ((num % den != 0) && ((num < 0) != (den < 0))) q = q - 1;
    q  = q + sb;
    // A zero size gives an upper bound of -1, which the lower clamp lifts
    // back to 0. Sizes past the output range stop at its largest value.
    hi = longint'({48'd0, it.src_size}) - 1;
    if (hi > 32767) hi = 32767;
    if (q > hi) q = hi;
    if (q < 0) q = 0;
    r.src_coord = q[OUT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  // An item is taken at an edge where start is high and busy is low. The
  // expectation is recorded at that same edge. The sender alternates bursts
  // of back-to-back items with random gaps; a quarter of the gaps are empty,
  // so long unbroken stretches occur as well.
  always @(posedge clk_i or negedge rst_ni) begin : item_sender
    int burst_left;
    int gap_left;
    if (!rst_ni) begin
      start      <= 1'b0;
      axis_item  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        src_coord_due_q.push_back(nearest_src_coord(axis_item));
        items_taken++;
      end
      if (start && busy) begin
        // The block has not taken the item yet: keep it on the port.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (axis_req_q.size() != 0) begin
        axis_item <= axis_req_q.pop_front();
        start     <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // The block cannot be held off, so every strobe is a result taken at the
  // edge that ends its cycle. Results come back in the order of their items.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (src_coord_due_q.size() == 0) begin
        report_mismatch("unexpected result (src_coord)", 0, 32'(result_o.src_coord));
      end else begin
        want = src_coord_due_q.pop_front();
        if (result_o.src_coord !== want.src_coord)
          report_mismatch("src_coord", 32'(want.src_coord), 32'(result_o.src_coord));
        if (result_o.empty_axis !== want.empty_axis)
          report_mismatch("empty_axis", 32'(want.empty_axis), 32'(result_o.empty_axis));
      end
    end
  end

  // Watchdog: counts cycles with no movement on either side.
  always @(posedge clk_i) begin : stall_watch
    int unsigned idle_cycles;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, src_coord_due_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------

  function automatic in_item_t axis_of(int d, int db, int de, int sb, int se, int sz);
    in_item_t it;
    it.dst_coord = 16'(d);
    it.dst_begin = 16'(db);
    it.dst_end   = 16'(de);
    it.src_begin = 16'(sb);
    it.src_end   = 16'(se);
    it.src_size  = 16'(sz);
    return it;
  endfunction

  initial begin : stimulus
    int       pick, sz, sb, se, db, de, d, lo, hi;
    in_item_t it;

    // Directed part: plain scaling both ways, empty destination regions,
    // mirrored destination and source regions, sizes of zero, one, exactly
    // 32768 and beyond, negative results, coordinates outside the region and
    // the extremes of every field.
    axis_req_q.push_back(axis_of(0, 0, 4, 0, 8, 8));
    axis_req_q.push_back(axis_of(15, 0, 16, 0, 8, 8));
    axis_req_q.push_back(axis_of(7, 5, 5, 0, 100, 200));
    axis_req_q.push_back(axis_of(32767, -32768, -32768, 3, 9, 10));
    axis_req_q.push_back(axis_of(3, 10, 0, 0, 20, 32));
    axis_req_q.push_back(axis_of(3, 0, 10, 20, 0, 32));
    axis_req_q.push_back(axis_of(9, 10, 0, 20, 0, 32));
    axis_req_q.push_back(axis_of(2, 0, 4, 0, 8, 0));
    axis_req_q.push_back(axis_of(2, 0, 4, 0, 8, 1));
    axis_req_q.push_back(axis_of(0, 0, 1, 32767, 32767, 16'h8000));
    axis_req_q.push_back(axis_of(0, 0, 1, 32767, 32767, 16'hFFFF));
    axis_req_q.push_back(axis_of(0, 0, 1, -32768, 32767, 16'hFFFF));
    axis_req_q.push_back(axis_of(4, 0, 8, -100, -10, 50));
    axis_req_q.push_back(axis_of(-20, 0, 8, 0, 16, 64));
    axis_req_q.push_back(axis_of(30, 0, 8, 0, 16, 64));
    axis_req_q.push_back(axis_of(-32768, 32767, -32768, -32768, 32767, 16'hFFFF));
    axis_req_q.push_back(axis_of(32767, -32768, 32767, 32767, -32768, 16'hFFFF));
    axis_req_q.push_back(axis_of(0, 0, 1, 0, 0, 0));
    axis_req_q.push_back(axis_of(-1, -1, -1, -1, -1, 16'hFFFF));
    axis_req_q.push_back(axis_of(-1, -1, 32767, -1, -1, 16'hFFFF));
    axis_req_q.push_back(axis_of(100, 100, 101, 5000, 5001, 5001));
    directed_cnt = axis_req_q.size();

    // Random part. Most items are believable blits: a source span inside an
    // image of random size, a destination span of random direction, and a
    // coordinate mostly inside it. The rest are empty regions and raw noise
    // in every bit of every field.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(1, 1024);
        sb = $urandom_range(0, (sz > 32767) ? 32767 : sz);
        se = $urandom_range(0, (sz > 32767) ? 32767 : sz);
        db = int'($urandom_range(0, 2000)) - 500;
        de = db + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 600));
        lo = (db < de) ? db : de;
        hi = (db < de) ? de : db;
        d  = lo + int'($urandom_range(0, hi - lo - 1));
        if ($urandom_range(0, 9) == 0) d = d + int'($urandom_range(0, 80)) - 40;
        if ((de < db) || (se < sb)) mirrored_cnt++;
        it = axis_of(d, db, de, sb, se, sz);
      end else if (pick < 75) begin
        it           = in_item_t'({$urandom(), $urandom(), $urandom()});
        it.dst_end   = it.dst_begin;
        empty_cnt++;
      end else begin
        it = in_item_t'({$urandom(), $urandom(), $urandom()});
      end
      axis_req_q.push_back(it);
    end

    // Wait on falling edges so that the driver's updates of the same step
    // have settled before they are read.
    while (axis_req_q.size() != 0 || start) @(negedge clk_i);
    while (src_coord_due_q.size() != 0) @(negedge clk_i);
    // Wait out more than the whole pipeline to catch any stray result behind the last one.
    repeat (LATENCY + 10) @(negedge clk_i);

    $display("Sent %0d axis items (%0d directed, %0d random with %0d mirrored and %0d empty)",
             items_taken, directed_cnt, NUM_RANDOM, mirrored_cnt, empty_cnt);
    $display("Checked %0d source coordinates, %0d mismatches", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bnc_pkg.sv
rtl/bnc_div_pipe.sv
rtl/blit_nearest_coordinate_scaler.sv
rtl/bnc_checker.sv
tb/tb_top.sv
